// File: hdl/crb_pkg.sv
// ----------------------------------------------------------------------------
// Coverage run builder package
// Shared widths, payload structures, event type and sequencer states.
// ----------------------------------------------------------------------------
package crb_pkg;

   localparam int POS_W   = 32;
   localparam int LEN_W   = 16;
   localparam int DEPTH_W = 5;

   // One input request: an aligned block.
   typedef struct packed {
      logic [POS_W-1:0] block_start;
      logic [LEN_W-1:0] block_length;
      logic             last;
   } req_type;

   // One result: a coverage run.
   typedef struct packed {
      logic [POS_W-1:0]   run_start;
      logic [DEPTH_W-1:0] run_depth;
      logic               overflow;
      logic               run_last;
   } rsp_type;

   // A sweep event: a block start (+1) or a block end (-1).
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             is_end;
   } event_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_FILL,
      ST_SECOND,
      ST_SETTLE,
      ST_ZERO,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

endpackage

// File: hdl/crb_cell.sv
// ----------------------------------------------------------------------------
// Coverage run builder sorting cell
// One stage of the systolic insertion sorter: holds one event, keeps the
// smaller of its own and the arriving event and hands the larger on.
// ----------------------------------------------------------------------------
module crb_cell #(
   parameter int INDEX = 0,
   parameter int TAG_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic                carry_valid_in,
   input  logic [TAG_W-1:0]    carry_tag_in,
   input  crb_pkg::event_type  carry_event_in,
   input  crb_pkg::event_type  right_event,
   output crb_pkg::event_type  held_event,
   output logic                carry_valid_out,
   output logic [TAG_W-1:0]    carry_tag_out,
   output crb_pkg::event_type  carry_event_out,
   output logic                busy
);

   logic               in_valid_ff;
   logic [TAG_W-1:0]   in_tag_ff;
   crb_pkg::event_type in_event_ff;
   crb_pkg::event_type held_ff;
   crb_pkg::event_type held_in;
   logic               land;
   logic               swap;

   // The tag counts the events stored ahead of this one, so an event lands
   // in the cell whose index equals its tag: the first free cell.
   always_comb begin
      land = in_valid_ff && (in_tag_ff == TAG_W'(INDEX));
      swap = in_event_ff.position < held_ff.position;
   end

   // Next held event: shift towards the head, or keep the smaller event.
   always_comb begin
      held_in = held_ff;
      if (shift) begin
         held_in = right_event;
      end else if (in_valid_ff && (land || swap)) begin
         held_in = in_event_ff;
      end
   end

   // Displaced event travels on to the next cell.
   always_comb begin
      carry_valid_out = in_valid_ff && !land;
      carry_tag_out   = in_tag_ff;
      carry_event_out = swap ? held_ff : in_event_ff;
      held_event      = held_ff;
      busy            = in_valid_ff;
   end

   // Arrival register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= carry_valid_in;
      end
   end

   // Event payload registers.
   always_ff @(posedge clock) begin
      in_tag_ff   <= carry_tag_in;
      in_event_ff <= carry_event_in;
      held_ff     <= held_in;
   end

endmodule

// File: hdl/crb_sorter.sv
// ----------------------------------------------------------------------------
// Coverage run builder sorter
// A row of sorting cells. Events enter at the head and ripple one cell per
// cycle; after settling, the row shifts towards the head in sorted order.
// ----------------------------------------------------------------------------
module crb_sorter #(
   parameter int SLOTS = 32,
   parameter int TAG_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               ins_valid,
   input  logic [TAG_W-1:0]   ins_tag,
   input  crb_pkg::event_type ins_event,
   input  logic               shift,
   output crb_pkg::event_type head_event,
   output crb_pkg::event_type next_event,
   output logic               busy
);

   logic               carry_valid [SLOTS+1];
   logic [TAG_W-1:0]   carry_tag   [SLOTS+1];
   crb_pkg::event_type carry_event [SLOTS+1];
   crb_pkg::event_type held        [SLOTS];
   logic [SLOTS-1:0]   busy_vec;

   // New events enter at the head cell.
   assign carry_valid[0] = ins_valid;
   assign carry_tag[0]   = ins_tag;
   assign carry_event[0] = ins_event;

   // The row of cells.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      crb_pkg::event_type right;
      if (i == SLOTS - 1) begin : g_tail
         assign right = held[i];
      end else begin : g_body
         assign right = held[i+1];
      end
      crb_cell #(
         .INDEX (i),
         .TAG_W (TAG_W)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .shift           (shift),
         .carry_valid_in  (carry_valid[i]),
         .carry_tag_in    (carry_tag[i]),
         .carry_event_in  (carry_event[i]),
         .right_event     (right),
         .held_event      (held[i]),
         .carry_valid_out (carry_valid[i+1]),
         .carry_tag_out   (carry_tag[i+1]),
         .carry_event_out (carry_event[i+1]),
         .busy            (busy_vec[i])
      );
   end

   // The sweep reads the two front cells; busy while any event is in flight.
   always_comb begin
      head_event = held[0];
      next_event = held[1];
      busy       = |busy_vec;
   end

endmodule

// File: hdl/coverage_run_builder_core.sv
// ----------------------------------------------------------------------------
// Coverage run builder
// Builds a run-length coverage map from aligned blocks with a systolic
// insertion sorter and a sweep over the sorted events.
// ----------------------------------------------------------------------------
// Use: requests (block start, length, last) arrive on the req_ channel and
// coverage runs leave on the rsp_ channel, both valid/ready. Each stored
// block becomes a +1 event at its start and a -1 event at its saturated end.
// A request is taken in ST_FILL, where its start event enters the head of the
// cell row; its end event follows in ST_SECOND, before the next request is
// taken. Blocks beyond MAX_BLOCKS are dropped and flagged. After the request
// marked last, the row settles while the final events ripple to their cells
// (N stored events, at most 2*MAX_BLOCKS), then the sweep pops one event per
// cycle from the head while the output registers have room, and the final run
// of the map is offered once all N events have been swept.
// One run is held back until the next is known, so that the final one
// carries run_last; results sit in an output register, and a stalled
// receiver simply holds the sweep. No requests are taken during the sweep.
// Synchronous reset empties the map and clears the overflow flag; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module coverage_run_builder_core #(
   parameter int MAX_BLOCKS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  crb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output crb_pkg::rsp_type rsp_payload
);

   localparam int SLOTS = 2 * MAX_BLOCKS;
   localparam int CW    = $clog2(SLOTS + 1);

   localparam int POS_W   = crb_pkg::POS_W;
   localparam int DEPTH_W = crb_pkg::DEPTH_W;

   crb_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       count_ff;
   logic                ovf_ff;
   logic                last_ff;
   logic                stored_ff;
   logic [POS_W-1:0]    end_pos_ff;
   logic [CW-1:0]       remain_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [DEPTH_W-1:0]  shown_ff;
   logic                pend_v_ff;
   crb_pkg::rsp_type    pend_ff;
   logic                out_v_ff;
   crb_pkg::rsp_type    out_ff;

   logic                accept;
   logic                fits;
   logic [POS_W:0]      end_sum;
   logic [POS_W-1:0]    end_sat;
   logic                ins_valid;
   crb_pkg::event_type  ins_event;
   logic                shift;
   logic                busy;
   crb_pkg::event_type  head_event;
   crb_pkg::event_type  next_event;
   logic                have;
   logic                group_end;
   logic [DEPTH_W-1:0]  depth_step;
   logic                out_free;
   logic                room;
   logic                produce;
   logic                produce_go;
   logic [POS_W-1:0]    new_pos;
   logic [DEPTH_W-1:0]  new_depth;
   logic                flush;

   // Request side arithmetic: end position saturates at the top.
   always_comb begin
      accept  = req_valid && req_ready;
      fits    = ({1'b0, count_ff} + (CW+1)'(2)) <= (CW+1)'(SLOTS);
      end_sum = {1'b0, req_payload.block_start} + (POS_W+1)'(req_payload.block_length);
      end_sat = end_sum[POS_W] ? {POS_W{1'b1}} : end_sum[POS_W-1:0];
   end

   // Sweep arithmetic on the head of the row.
   always_comb begin
      have       = remain_ff != '0;
      group_end  = (remain_ff == CW'(1)) || (next_event.position != head_event.position);
      depth_step = head_event.is_end ? depth_ff - DEPTH_W'(1) : depth_ff + DEPTH_W'(1);
      out_free   = !out_v_ff || rsp_ready;
      room       = !pend_v_ff || out_free;
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      ins_valid = 1'b0;
      ins_event = '{position: req_payload.block_start, is_end: 1'b0};
      shift     = 1'b0;
      produce   = 1'b0;
      new_pos   = '0;
      new_depth = depth_ff;
      flush     = 1'b0;
      case (state_ff)
         crb_pkg::ST_FILL: begin
            req_ready = 1'b1;
            ins_valid = req_valid && fits;
         end
         crb_pkg::ST_SECOND: begin
            ins_valid = stored_ff;
            ins_event = '{position: end_pos_ff, is_end: 1'b1};
         end
         crb_pkg::ST_ZERO: begin
            if (have && (head_event.position == '0)) begin
               shift = 1'b1;
            end else begin
               produce = 1'b1;
            end
         end
         crb_pkg::ST_SWEEP: begin
            if (have) begin
               if (group_end && (depth_step != shown_ff)) begin
                  produce   = 1'b1;
                  new_pos   = head_event.position;
                  new_depth = depth_step;
                  shift     = room;
               end else begin
                  shift = 1'b1;
               end
            end
         end
         crb_pkg::ST_FLUSH: begin
            flush = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      produce_go = produce && room;
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crb_pkg::ST_FILL: begin
            if (accept) state_in = crb_pkg::ST_SECOND;
         end
         crb_pkg::ST_SECOND: begin
            state_in = last_ff ? crb_pkg::ST_SETTLE : crb_pkg::ST_FILL;
         end
         crb_pkg::ST_SETTLE: begin
            if (!busy) state_in = crb_pkg::ST_ZERO;
         end
         crb_pkg::ST_ZERO: begin
            if (produce_go) state_in = crb_pkg::ST_SWEEP;
         end
         crb_pkg::ST_SWEEP: begin
            if (!have) state_in = crb_pkg::ST_FLUSH;
         end
         crb_pkg::ST_FLUSH: begin
            if (flush) state_in = crb_pkg::ST_FILL;
         end
         default: begin
            state_in = crb_pkg::ST_FILL;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= crb_pkg::ST_FILL;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         remain_ff <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ins_valid) begin
            count_ff <= count_ff + CW'(1);
         end else if (flush) begin
            count_ff <= '0;
         end
         if (accept && !fits) begin
            ovf_ff <= 1'b1;
         end else if (flush) begin
            ovf_ff <= 1'b0;
         end
         if ((state_ff == crb_pkg::ST_SETTLE) && !busy) begin
            remain_ff <= count_ff;
         end else if (shift) begin
            remain_ff <= remain_ff - CW'(1);
         end
         if (produce_go) begin
            pend_v_ff <= 1'b1;
         end else if (flush) begin
            pend_v_ff <= 1'b0;
         end
         if ((produce_go && pend_v_ff) || flush) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         end_pos_ff <= end_sat;
         last_ff    <= req_payload.last;
         stored_ff  <= fits;
      end
      if ((state_ff == crb_pkg::ST_SETTLE) && !busy) begin
         depth_ff <= '0;
      end else if (shift) begin
         depth_ff <= depth_step;
      end
      if (produce_go) begin
         shown_ff <= new_depth;
         pend_ff  <= '{run_start: new_pos, run_depth: new_depth,
                       overflow: ovf_ff, run_last: 1'b0};
      end
      if (produce_go && pend_v_ff) begin
         out_ff <= pend_ff;
      end else if (flush) begin
         out_ff <= '{run_start: pend_ff.run_start, run_depth: pend_ff.run_depth,
                     overflow: pend_ff.overflow, run_last: 1'b1};
      end
   end

   // Sorting row.
   crb_sorter #(
      .SLOTS (SLOTS),
      .TAG_W (CW)
   ) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .ins_valid  (ins_valid),
      .ins_tag    (count_ff),
      .ins_event  (ins_event),
      .shift      (shift),
      .head_event (head_event),
      .next_event (next_event),
      .busy       (busy)
   );

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   // The stored event count never exceeds the row length.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("event count beyond capacity");

   // The row only shifts once every event has reached its cell.
   a_shift_settled: assert property (@(posedge clock) disable iff (reset)
      shift |-> !busy)
      else $error("shift while events are in flight");

   // The held-back run is always present when the map is being closed.
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crb_pkg::ST_FLUSH) |-> pend_v_ff)
      else $error("closing the map without a pending run");

   // Closing the map empties it and clears the overflow flag.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      flush |=> ((count_ff == '0) && !ovf_ff && !pend_v_ff && rsp_valid))
      else $error("map state not cleared after the final run");

endmodule
